FILE: rtl/lobt_pkg.sv
// ----------------------------------------------------------------------------
// lobt_pkg: shared types and codes of the order book table.
// Holds the table entry layout, operation and status codes and the
// controller state and command types.
// ----------------------------------------------------------------------------
package lobt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic               side;
    logic [31:0]        price;
    logic [31:0]        quantity;
    logic [31:0]        filled;
    logic signed [32:0] remaining;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

FILE: rtl/lobt_ctrl.sv
// ----------------------------------------------------------------------------
// lobt_ctrl: sequencer of the order book table.
// Steps each item through load, table scan, drain, finish and output.
// ----------------------------------------------------------------------------
module lobt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lobt_pkg::stat_t stat,
  output lobt_pkg::cmd_t  cmd
);

  lobt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lobt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lobt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lobt_pkg::S_SCAN;
      end
      lobt_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = lobt_pkg::S_DRAIN;
      end
      lobt_pkg::S_DRAIN:  state_nxt = lobt_pkg::S_FINISH;
      lobt_pkg::S_FINISH: state_nxt = lobt_pkg::S_OUT;
      lobt_pkg::S_OUT: begin
        if (!out_stall) state_nxt = lobt_pkg::S_IDLE;
      end
      default: state_nxt = lobt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != lobt_pkg::S_IDLE);
    out_valid  = (state_r == lobt_pkg::S_OUT);
    cmd.load   = (state_r == lobt_pkg::S_IDLE) && in_valid;
    cmd.issue  = (state_r == lobt_pkg::S_SCAN);
    cmd.finish = (state_r == lobt_pkg::S_FINISH);
  end

endmodule

FILE: rtl/lobt_dp.sv
// ----------------------------------------------------------------------------
// lobt_dp: datapath of the order book table.
// Holds the entry memory and valid bits, scans one entry a cycle for the id
// match, the lowest free slot and the best prices, then applies the item.
// ----------------------------------------------------------------------------
module lobt_dp #(
  parameter int MAX_ORDERS = 64,
  parameter int IW = $clog2(MAX_ORDERS),
  parameter int CW = $clog2(MAX_ORDERS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lobt_pkg::cmd_t     cmd,
  output lobt_pkg::stat_t    stat,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_order_id,
  input  logic               in_side,
  input  logic [31:0]        in_price,
  input  logic [31:0]        in_quantity,
  input  logic [31:0]        in_filled_qty,
  input  logic signed [32:0] in_remaining_qty,
  output logic [2:0]         out_status,
  output logic               out_order_side,
  output logic [31:0]        out_order_price,
  output logic [31:0]        out_order_quantity,
  output logic [31:0]        out_order_filled,
  output logic signed [32:0] out_order_remaining,
  output logic               out_bid_valid,
  output logic [31:0]        out_best_bid,
  output logic               out_ask_valid,
  output logic [31:0]        out_best_ask,
  output logic signed [32:0] out_spread_ticks,
  output logic [CW-1:0]      out_order_count
);

  lobt_pkg::entry_t mem [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] valid_r;
  logic [CW-1:0] count_r;

  lobt_pkg::op_t op_r;
  lobt_pkg::entry_t req_r;
  logic [IW-1:0] cnt_r, idx_r, hit_idx_r, free_idx_r;
  logic rd_en_r, hit_r, free_r;
  lobt_pkg::entry_t rd_r, hit_e_r;
  logic bv_r, av_r;
  logic [31:0] bid_r, ask_r;

  logic cur_valid;
  assign cur_valid = valid_r[idx_r];
  assign stat.scan_last = (cnt_r == IW'(MAX_ORDERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_r  <= mem[cnt_r];
      idx_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_en_r <= 1'b0;
    end else begin
      rd_en_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r            <= lobt_pkg::op_t'(in_operation);
      req_r.tag       <= in_order_id;
      req_r.side      <= in_side;
      req_r.price     <= in_price;
      req_r.quantity  <= in_quantity;
      req_r.filled    <= in_filled_qty;
      req_r.remaining <= in_remaining_qty;
      cnt_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      bv_r <= 1'b0;
      av_r <= 1'b0;
      bid_r <= '0;
      ask_r <= '0;
    end else begin
      if (cmd.issue) cnt_r <= cnt_r + 1'b1;
      if (rd_en_r) begin
        if (cur_valid && rd_r.tag == req_r.tag) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx_r;
          hit_e_r   <= rd_r;
        end else if (cur_valid) begin
          if (!rd_r.side) begin
            if (!bv_r || rd_r.price > bid_r) bid_r <= rd_r.price;
            bv_r <= 1'b1;
          end else begin
            if (!av_r || rd_r.price < ask_r) ask_r <= rd_r.price;
            av_r <= 1'b1;
          end
        end else if (!free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= idx_r;
        end
      end
    end
  end

  // Finish step: outcome, table update and a final fold of one candidate.
  lobt_pkg::status_t st;
  lobt_pkg::entry_t ord, mod_e;
  logic cand, wr_en, set_v, clr_v;
  logic [IW-1:0] wr_idx;
  lobt_pkg::entry_t wr_e;
  logic fbv, fav;
  logic [31:0] fbid, fask;

  always_comb begin
    mod_e = hit_e_r;
    mod_e.price = req_r.price;
    mod_e.quantity = req_r.quantity;
    mod_e.remaining = $signed({1'b0, req_r.quantity}) - $signed({1'b0, hit_e_r.filled});
    st = lobt_pkg::ST_OK;
    ord = '0;
    cand = 1'b0;
    wr_en = 1'b0;
    set_v = 1'b0;
    clr_v = 1'b0;
    wr_idx = hit_idx_r;
    wr_e = mod_e;
    if (op_r == lobt_pkg::OP_ADD) begin
      if (req_r.remaining[32] || req_r.remaining == '0) begin
        st = lobt_pkg::ST_IGNORED;
        cand = hit_r;
      end else if (hit_r) begin
        st = lobt_pkg::ST_DUPLICATE;
        cand = 1'b1;
      end else if (!free_r) begin
        st = lobt_pkg::ST_FULL;
      end else begin
        ord = req_r;
        cand = 1'b1;
        wr_en = 1'b1;
        set_v = 1'b1;
        wr_idx = free_idx_r;
        wr_e = req_r;
      end
    end else if (!hit_r) begin
      st = lobt_pkg::ST_NOT_FOUND;
    end else begin
      unique case (op_r)
        lobt_pkg::OP_REMOVE: begin
          ord = hit_e_r;
          clr_v = 1'b1;
        end
        lobt_pkg::OP_MODIFY: begin
          ord = mod_e;
          cand = 1'b1;
          wr_en = 1'b1;
        end
        default: begin
          ord = hit_e_r;
          cand = 1'b1;
        end
      endcase
    end
    if (op_r == lobt_pkg::OP_ADD && hit_r) begin
      ord = '0;
      ord.side = hit_e_r.side;
      ord.price = hit_e_r.price;
    end
    fbv = bv_r;
    fav = av_r;
    fbid = bid_r;
    fask = ask_r;
    if (cand && !ord.side) begin
      if (!bv_r || ord.price > bid_r) fbid = ord.price;
      fbv = 1'b1;
    end
    if (cand && ord.side) begin
      if (!av_r || ord.price < ask_r) fask = ord.price;
      fav = 1'b1;
    end
    if (st != lobt_pkg::ST_OK) ord = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) mem[wr_idx] <= wr_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.finish) begin
      if (set_v) begin
        valid_r[wr_idx] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (clr_v) begin
        valid_r[hit_idx_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status          <= st;
      out_order_side      <= ord.side;
      out_order_price     <= ord.price;
      out_order_quantity  <= ord.quantity;
      out_order_filled    <= ord.filled;
      out_order_remaining <= ord.remaining;
      out_bid_valid       <= fbv;
      out_best_bid        <= fbid;
      out_ask_valid       <= fav;
      out_best_ask        <= fask;
      out_spread_ticks    <= (fbv && fav) ? $signed({1'b0, fask} - {1'b0, fbid}) : '0;
      out_order_count     <= count_r + CW'(set_v) - CW'(clr_v);
    end
  end

endmodule

FILE: rtl/limit_order_book_table.sv
// ----------------------------------------------------------------------------
// limit_order_book_table: bounded table of resting buy and sell orders.
// Adds, removes, modifies and queries orders by id and reports best prices.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   operation and order fields
//   out_     output     out_valid/out_stall status, order, book summary
//
// An item is scanned against the entry memory one entry a cycle, then
// passes drain and finish to a valid result; the next item is taken after
// the result leaves. Reset clears all valid bits and the order count at
// once. A stalled result holds and the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module limit_order_book_table #(
  parameter int MAX_ORDERS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_order_id,
  input  logic               in_side,
  input  logic [31:0]        in_price,
  input  logic [31:0]        in_quantity,
  input  logic [31:0]        in_filled_qty,
  input  logic signed [32:0] in_remaining_qty,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_order_side,
  output logic [31:0]        out_order_price,
  output logic [31:0]        out_order_quantity,
  output logic [31:0]        out_order_filled,
  output logic signed [32:0] out_order_remaining,
  output logic               out_bid_valid,
  output logic [31:0]        out_best_bid,
  output logic               out_ask_valid,
  output logic [31:0]        out_best_ask,
  output logic signed [32:0] out_spread_ticks,
  output logic [$clog2(MAX_ORDERS+1)-1:0] out_order_count
);

  lobt_pkg::cmd_t  cmd;
  lobt_pkg::stat_t stat;

  lobt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  lobt_dp #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_operation(in_operation), .in_order_id(in_order_id), .in_side(in_side),
    .in_price(in_price), .in_quantity(in_quantity), .in_filled_qty(in_filled_qty),
    .in_remaining_qty(in_remaining_qty),
    .out_status(out_status), .out_order_side(out_order_side),
    .out_order_price(out_order_price), .out_order_quantity(out_order_quantity),
    .out_order_filled(out_order_filled), .out_order_remaining(out_order_remaining),
    .out_bid_valid(out_bid_valid), .out_best_bid(out_best_bid),
    .out_ask_valid(out_ask_valid), .out_best_ask(out_best_ask),
    .out_spread_ticks(out_spread_ticks), .out_order_count(out_order_count)
  );

endmodule

FILE: rtl/lobt_checker.sv
// ----------------------------------------------------------------------------
// lobt_checker: port level checks of the order book table.
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module lobt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [31:0]        out_order_price,
  input logic [31:0]        out_order_quantity,
  input logic               out_bid_valid,
  input logic               out_ask_valid,
  input logic signed [32:0] out_spread_ticks,
  input logic [31:0]        out_best_bid
);

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("input open while a result waits");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lobt_pkg::ST_OK |->
      out_order_price == '0 && out_order_quantity == '0)
    else $error("failed item carries order fields");

  a_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_bid_valid && out_ask_valid) |-> out_spread_ticks == '0)
    else $error("spread without both sides");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_bid))
    else $error("stalled result changed");

endmodule

bind limit_order_book_table lobt_checker u_lobt_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_status(out_status), .out_order_price(out_order_price),
  .out_order_quantity(out_order_quantity), .out_bid_valid(out_bid_valid),
  .out_ask_valid(out_ask_valid), .out_spread_ticks(out_spread_ticks),
  .out_best_bid(out_best_bid)
);

FILE: tb/order_book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_checker: scoreboard for the order book table.
// Watches both channels, keeps its own copy of the book to work out the
// result of every accepted item, and compares each result field by field.
// ----------------------------------------------------------------------------
module order_book_checker #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_order_id,
  input  logic               in_side,
  input  logic [31:0]        in_price,
  input  logic [31:0]        in_quantity,
  input  logic [31:0]        in_filled_qty,
  input  logic signed [32:0] in_remaining_qty,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic               out_order_side,
  input  logic [31:0]        out_order_price,
  input  logic [31:0]        out_order_quantity,
  input  logic [31:0]        out_order_filled,
  input  logic signed [32:0] out_order_remaining,
  input  logic               out_bid_valid,
  input  logic [31:0]        out_best_bid,
  input  logic               out_ask_valid,
  input  logic [31:0]        out_best_ask,
  input  logic signed [32:0] out_spread_ticks,
  input  logic [6:0]         out_order_count,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [2:0]         status;
    logic               side;
    logic [31:0]        price;
    logic [31:0]        quantity;
    logic [31:0]        filled;
    logic signed [32:0] remaining;
    logic               bid_valid;
    logic [31:0]        best_bid;
    logic               ask_valid;
    logic [31:0]        best_ask;
    logic signed [32:0] spread;
    logic [6:0]         count;
  } book_result_t;

  book_result_t       results_due[$];
  logic               resting[DEPTH];
  logic [31:0]        tag_of[DEPTH];
  logic               side_of[DEPTH];
  logic [31:0]        price_of[DEPTH];
  logic [31:0]        qty_of[DEPTH];
  logic [31:0]        filled_of[DEPTH];
  logic signed [33:0] rem_of[DEPTH];
  int                 book_size;

  task automatic report_order(input int i, inout book_result_t r);
    r.side      = side_of[i];
    r.price     = price_of[i];
    r.quantity  = qty_of[i];
    r.filled    = filled_of[i];
    r.remaining = rem_of[i][32:0];
  endtask

  task automatic apply_order(input logic [1:0] op, input logic [31:0] tag,
                             input logic side, input logic [31:0] price,
                             input logic [31:0] qty, input logic [31:0] filled,
                             input logic signed [32:0] rem,
                             output book_result_t r);
    int hit;
    int slot;
    logic signed [33:0] rem34;
    logic signed [33:0] diff;
    r = '0;
    hit = -1;
    slot = -1;
    rem34 = {rem[32], rem};
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && resting[i] && tag_of[i] == tag) hit = i;
    end
    if (op == lobt_pkg::OP_ADD) begin
      if (rem34 <= 0) begin
        r.status = lobt_pkg::ST_IGNORED;
      end else if (hit >= 0) begin
        r.status = lobt_pkg::ST_DUPLICATE;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot < 0 && !resting[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = lobt_pkg::ST_FULL;
        end else begin
          resting[slot]   = 1'b1;
          tag_of[slot]    = tag;
          side_of[slot]   = side;
          price_of[slot]  = price;
          qty_of[slot]    = qty;
          filled_of[slot] = filled;
          rem_of[slot]    = rem34;
          book_size++;
          r.status = lobt_pkg::ST_OK;
          report_order(slot, r);
        end
      end
    end else if (hit < 0) begin
      r.status = lobt_pkg::ST_NOT_FOUND;
    end else begin
      r.status = lobt_pkg::ST_OK;
      if (op == lobt_pkg::OP_REMOVE) begin
        report_order(hit, r);
        resting[hit] = 1'b0;
        book_size--;
      end else begin
        if (op == lobt_pkg::OP_MODIFY) begin
          price_of[hit] = price;
          qty_of[hit]   = qty;
          rem_of[hit]   = $signed({2'b00, qty}) - $signed({2'b00, filled_of[hit]});
        end
        report_order(hit, r);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (resting[i]) begin
        if (side_of[i] == 1'b0) begin
          if (!r.bid_valid || price_of[i] > r.best_bid) r.best_bid = price_of[i];
          r.bid_valid = 1'b1;
        end else begin
          if (!r.ask_valid || price_of[i] < r.best_ask) r.best_ask = price_of[i];
          r.ask_valid = 1'b1;
        end
      end
    end
    if (r.bid_valid && r.ask_valid) begin
      diff = $signed({2'b00, r.best_ask}) - $signed({2'b00, r.best_bid});
      r.spread = diff[32:0];
    end
    r.count = book_size[6:0];
  endtask

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    book_result_t r;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) resting[i] = 1'b0;
      book_size = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result item with no item pending");
          errors++;
        end else begin
          r = results_due.pop_front();
          check_field("status", r.status, out_status);
          check_field("order_side", r.side, out_order_side);
          check_field("order_price", r.price, out_order_price);
          check_field("order_quantity", r.quantity, out_order_quantity);
          check_field("order_filled", r.filled, out_order_filled);
          check_field("order_remaining", r.remaining, out_order_remaining);
          check_field("bid_valid", r.bid_valid, out_bid_valid);
          check_field("best_bid", r.best_bid, out_best_bid);
          check_field("ask_valid", r.ask_valid, out_ask_valid);
          check_field("best_ask", r.best_ask, out_best_ask);
          check_field("spread_ticks", r.spread, out_spread_ticks);
          check_field("order_count", r.count, out_order_count);
        end
      end
      if (in_valid && !in_stall) begin
        apply_order(in_operation, in_order_id, in_side, in_price, in_quantity,
                    in_filled_qty, in_remaining_qty, r);
        results_due = {results_due, r};
      end
    end
    pending = results_due.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the order book table.
// Runs directed cases on each operation and all statuses but full, then random
// traffic over a small id pool with table fill bursts, random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = 64;
  localparam int HANG_LIMIT = 4000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [31:0]        in_order_id;
  logic               in_side;
  logic [31:0]        in_price;
  logic [31:0]        in_quantity;
  logic [31:0]        in_filled_qty;
  logic signed [32:0] in_remaining_qty;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic               out_order_side;
  logic [31:0]        out_order_price;
  logic [31:0]        out_order_quantity;
  logic [31:0]        out_order_filled;
  logic signed [32:0] out_order_remaining;
  logic               out_bid_valid;
  logic [31:0]        out_best_bid;
  logic               out_ask_valid;
  logic [31:0]        out_best_ask;
  logic signed [32:0] out_spread_ticks;
  logic [6:0]         out_order_count;
  int                 errors;
  int                 pending;
  int                 stall_left;
  int                 idle_cycles;
  logic               stall_on;

  limit_order_book_table #(.MAX_ORDERS(DEPTH)) dut (.*);

  order_book_checker #(.DEPTH(DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0:       stall_left <= $urandom_range(15, 40);
        1, 2, 3: stall_left <= $urandom_range(1, 3);
        default: stall_left <= 0;
      endcase
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input lobt_pkg::op_t op, input logic [31:0] id,
                           input logic side,
                           input logic [31:0] price, input logic [31:0] qty,
                           input logic [31:0] filled, input logic [32:0] rem);
    int gap;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_order_id      <= id;
    in_side          <= side;
    in_price         <= price;
    in_quantity      <= qty;
    in_filled_qty    <= filled;
    in_remaining_qty <= rem;
    do @(posedge clk); while (in_stall);
    case ($urandom_range(0, 9))
      0:          gap = $urandom_range(10, 30);
      1, 2, 3:    gap = $urandom_range(1, 3);
      default:    gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [32:0] rand_remaining();
    case ($urandom_range(0, 9))
      0:       return 33'd0;
      1:       return {1'b1, $urandom()};
      2:       return 33'd1;
      default: return {1'b0, $urandom() | 32'd1};
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    return $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 1000));
  endfunction

  initial begin
    logic [31:0] id;
    logic [31:0] fill_base;
    int          sent;
    int          pick;
    in_valid = 1'b0;
    in_operation = lobt_pkg::OP_ADD;
    in_order_id = '0;
    in_side = 1'b0;
    in_price = '0;
    in_quantity = '0;
    in_filled_qty = '0;
    in_remaining_qty = '0;
    stall_on = 1'b1;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(lobt_pkg::OP_QUERY, 32'd5, 1'b0, '0, '0, '0, '0);
    send_item(lobt_pkg::OP_REMOVE, 32'd5, 1'b0, '0, '0, '0, '0);
    send_item(lobt_pkg::OP_MODIFY, 32'd5, 1'b0, 32'd9, 32'd9, '0, '0);
    send_item(lobt_pkg::OP_ADD, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 33'd1);
    send_item(lobt_pkg::OP_ADD, '1, 1'b1, '1, '1, '1, {1'b0, 32'hFFFF_FFFF});
    send_item(lobt_pkg::OP_ADD, 32'd7, 1'b0, 32'd3, 32'd3, 32'd0, 33'd0);
    send_item(lobt_pkg::OP_ADD, 32'd8, 1'b1, 32'd3, 32'd3, 32'd0, '1);
    send_item(lobt_pkg::OP_ADD, 32'd9, 1'b1, 32'd3, 32'd3, 32'd0, {1'b1, 32'd1});
    send_item(lobt_pkg::OP_ADD, 32'd0, 1'b1, 32'd4, 32'd4, 32'd0, 33'd5);
    send_item(lobt_pkg::OP_ADD, 32'd0, 1'b1, 32'd4, 32'd4, 32'd0, 33'd0);
    send_item(lobt_pkg::OP_ADD, 32'd10, 1'b1, 32'd100, 32'd70, 32'd20, 33'd50);
    send_item(lobt_pkg::OP_ADD, 32'd11, 1'b0, 32'd200, 32'd3, 32'd0, 33'd3);
    send_item(lobt_pkg::OP_MODIFY, 32'd10, 1'b0, 32'd1, 32'd0, '0, '0);
    send_item(lobt_pkg::OP_QUERY, 32'd10, 1'b0, '0, '0, '0, '0);
    send_item(lobt_pkg::OP_MODIFY, '1, 1'b0, 32'd0, 32'd0, '0, '0);
    send_item(lobt_pkg::OP_REMOVE, 32'd11, 1'b0, '0, '0, '0, '0);
    send_item(lobt_pkg::OP_REMOVE, 32'd0, 1'b0, '0, '0, '0, '0);
    send_item(lobt_pkg::OP_QUERY, 32'd0, 1'b0, '0, '0, '0, '0);

    sent = 0;
    fill_base = 32'h1000_0000;
    while (sent < 600) begin
      if (sent % 200 == 50) begin
        // Fill the table past its capacity, then empty part of it again.
        for (int i = 0; i < DEPTH + 4; i++) begin
          send_item(lobt_pkg::OP_ADD, fill_base + i, 1'($urandom), $urandom(),
                    $urandom(), $urandom(), {1'b0, $urandom() | 32'd1});
        end
        for (int i = 0; i < DEPTH; i += 2) begin
          send_item(lobt_pkg::OP_REMOVE, fill_base + i, 1'b0, '0, '0, '0, '0);
        end
        fill_base += 32'h100;
        sent += DEPTH + 4 + DEPTH / 2;
      end
      if (sent > 380 && sent < 400) begin
        // Let all pending results drain, then run with no result stalls for a while.
        @(posedge clk);
        wait (pending == 0);
        stall_on = 1'b0;
      end
      if (sent > 450) stall_on = 1'b1;
      id = ($urandom_range(0, 6) == 0) ? $urandom() : 32'($urandom_range(0, 95));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_item(lobt_pkg::OP_ADD, id, 1'($urandom), rand_word(), rand_word(),
                  rand_word(), rand_remaining());
      end else if (pick < 6) begin
        send_item(lobt_pkg::OP_REMOVE, id, 1'($urandom), rand_word(), rand_word(),
                  rand_word(), rand_remaining());
      end else if (pick < 8) begin
        send_item(lobt_pkg::OP_MODIFY, id, 1'($urandom), rand_word(), rand_word(),
                  rand_word(), rand_remaining());
      end else begin
        send_item(lobt_pkg::OP_QUERY, id, 1'($urandom), rand_word(), rand_word(),
                  rand_word(), rand_remaining());
      end
      sent++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DEPTH + 20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: limit_order_book_table.f
rtl/lobt_pkg.sv
rtl/lobt_ctrl.sv
rtl/lobt_dp.sv
rtl/limit_order_book_table.sv
rtl/lobt_checker.sv
tb/order_book_checker.sv
tb/testbench.sv
